// ===== design/ftdp_pkg.sv =====
// ----------------------------------------------------------------------------
// ftdp_pkg
// Shared types and constants for the fused triple complex dot product block.
// ----------------------------------------------------------------------------
`default_nettype none

package ftdp_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int SUM_WIDTH    = 48;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int NUM_LANES    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONJUGATE = 2'd0,
        CFG_BETA_RE   = 2'd1,
        CFG_BETA_IM   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef struct packed {
        t_op                             op;
        logic signed [SAMPLE_WIDTH-1:0]  x_re;
        logic signed [SAMPLE_WIDTH-1:0]  x_im;
        logic signed [SAMPLE_WIDTH-1:0]  y_re;
        logic signed [SAMPLE_WIDTH-1:0]  y_im;
        logic signed [SAMPLE_WIDTH-1:0]  w_re;
        logic signed [SAMPLE_WIDTH-1:0]  w_im;
        logic signed [SAMPLE_WIDTH-1:0]  z_re;
        logic signed [SAMPLE_WIDTH-1:0]  z_im;
        logic                            last;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0]  xz_re;
        logic signed [SAMPLE_WIDTH-1:0]  xz_im;
        logic signed [SAMPLE_WIDTH-1:0]  yz_re;
        logic signed [SAMPLE_WIDTH-1:0]  yz_im;
        logic signed [SAMPLE_WIDTH-1:0]  wz_re;
        logic signed [SAMPLE_WIDTH-1:0]  wz_im;
    } t_out_item;

    // per-stage load enables and accumulator controls shared by all lanes
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld_out;
        logic acc_en;
        logic acc_clr;
    } t_lane_ctl;

endpackage

`default_nettype wire

// ===== design/fused_triple_dot_product.sv =====
// ----------------------------------------------------------------------------
// fused_triple_dot_product
// Three complex Q1.15 dot products against a shared z vector, with a
// beta-scaled prior term added when the last element arrives.
// ----------------------------------------------------------------------------
// One item enters per cycle while the input is not stalled. Data items run
// through a six-register pipeline (input, products, pair sums, accumulate,
// beta*prior add, rounded output), and the result of a last item is shown
// from the rounded output register. Load items only write the prior registers
// at acceptance. Stages hold only when the output register is full and stalled;
// empty stages keep filling, and the input stalls once every stage is busy.
// ----------------------------------------------------------------------------
`default_nettype none

module fused_triple_dot_product #(
    parameter int SUM_WIDTH = ftdp_pkg::SUM_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [ftdp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [ftdp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire ftdp_pkg::t_in_item                i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output ftdp_pkg::t_out_item                    o_out_item
);

    localparam int SW = ftdp_pkg::SAMPLE_WIDTH;
    localparam int NL = ftdp_pkg::NUM_LANES;

    logic                 r_conj;
    logic signed [SW-1:0] r_beta_re, r_beta_im;
    logic signed [SW-1:0] r_prior_re [NL];
    logic signed [SW-1:0] r_prior_im [NL];
    logic signed [SW-1:0] r_a_re [NL];
    logic signed [SW-1:0] r_a_im [NL];
    logic signed [SW-1:0] r_z_re, r_z_im;
    logic                 r_last1, r_last2, r_last3;
    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_vo;

    logic signed [SW-1:0] in_re [NL];
    logic signed [SW-1:0] in_im [NL];
    logic signed [SW-1:0] lane_re [NL];
    logic signed [SW-1:0] lane_im [NL];
    logic                 ld1, ld2, ld3, ld4, ld5, ld_out;
    logic                 in_acc;
    ftdp_pkg::t_lane_ctl  lane_ctl;

    always_comb begin
        in_re[0] = i_in_item.x_re;
        in_im[0] = i_in_item.x_im;
        in_re[1] = i_in_item.y_re;
        in_im[1] = i_in_item.y_im;
        in_re[2] = i_in_item.w_re;
        in_im[2] = i_in_item.w_im;
    end

    // a stage loads when empty or when its item moves on
    always_comb begin
        ld_out = !r_vo || !i_out_stall;
        ld5    = !r_v5 || ld_out;
        ld4    = !r_v4 || ld5;
        ld3    = !r_v3 || ld4;
        ld2    = !r_v2 || ld3;
        ld1    = !r_v1 || ld2;
        in_acc = i_in_valid && ld1;

        lane_ctl.ld2     = ld2;
        lane_ctl.ld3     = ld3;
        lane_ctl.ld4     = ld4;
        lane_ctl.ld5     = ld5;
        lane_ctl.ld_out  = ld_out;
        lane_ctl.acc_en  = r_v3 && ld4;
        lane_ctl.acc_clr = r_last3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_vo      <= 1'b0;
            r_conj    <= 1'b0;
            r_beta_re <= '0;
            r_beta_im <= '0;
            for (int k = 0; k < NL; k++) begin
                r_prior_re[k] <= '0;
                r_prior_im[k] <= '0;
            end
        end else begin
            if (ld1) begin
                r_v1 <= in_acc && (i_in_item.op == ftdp_pkg::OP_DATA);
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
            // only last items go on past the accumulator
            if (ld4) begin
                r_v4 <= r_v3 && r_last3;
            end
            if (ld5) begin
                r_v5 <= r_v4;
            end
            if (ld_out) begin
                r_vo <= r_v5;
            end
            if (in_acc && (i_in_item.op == ftdp_pkg::OP_LOAD)) begin
                for (int k = 0; k < NL; k++) begin
                    r_prior_re[k] <= in_re[k];
                    r_prior_im[k] <= in_im[k];
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ftdp_pkg::CFG_CONJUGATE: r_conj    <= i_cfg_data[0];
                    ftdp_pkg::CFG_BETA_RE:   r_beta_re <= i_cfg_data[SW-1:0];
                    ftdp_pkg::CFG_BETA_IM:   r_beta_im <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            for (int k = 0; k < NL; k++) begin
                r_a_re[k] <= in_re[k];
                r_a_im[k] <= in_im[k];
            end
            r_z_re  <= i_in_item.z_re;
            r_z_im  <= i_in_item.z_im;
            r_last1 <= i_in_item.last;
        end
        if (ld2) begin
            r_last2 <= r_last1;
        end
        if (ld3) begin
            r_last3 <= r_last2;
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        ftdp_lane #(
            .SUM_WIDTH (SUM_WIDTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (lane_ctl),
            .i_conj    (r_conj),
            .i_beta_re (r_beta_re),
            .i_beta_im (r_beta_im),
            .i_a_re    (r_a_re[g]),
            .i_a_im    (r_a_im[g]),
            .i_z_re    (r_z_re),
            .i_z_im    (r_z_im),
            .i_p_re    (r_prior_re[g]),
            .i_p_im    (r_prior_im[g]),
            .o_re      (lane_re[g]),
            .o_im      (lane_im[g])
        );
    end

    assign o_in_stall  = !ld1;
    assign o_out_valid = r_vo;

    always_comb begin
        o_out_item.xz_re = lane_re[0];
        o_out_item.xz_im = lane_im[0];
        o_out_item.yz_re = lane_re[1];
        o_out_item.yz_im = lane_im[1];
        o_out_item.wz_re = lane_re[2];
        o_out_item.wz_im = lane_im[2];
    end

endmodule

`default_nettype wire

// ===== design/ftdp_lane.sv =====
// ----------------------------------------------------------------------------
// ftdp_lane
// One complex lane: a*z products, pair sums, saturating accumulator and the
// final beta*prior + sum with Q1.15 rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ftdp_lane #(
    parameter int SUM_WIDTH = ftdp_pkg::SUM_WIDTH
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire ftdp_pkg::t_lane_ctl                    i_ctl,
    input  wire logic                                   i_conj,
    input  wire logic signed [ftdp_pkg::SAMPLE_WIDTH-1:0] i_beta_re,
    input  wire logic signed [ftdp_pkg::SAMPLE_WIDTH-1:0] i_beta_im,
    input  wire logic signed [ftdp_pkg::SAMPLE_WIDTH-1:0] i_a_re,
    input  wire logic signed [ftdp_pkg::SAMPLE_WIDTH-1:0] i_a_im,
    input  wire logic signed [ftdp_pkg::SAMPLE_WIDTH-1:0] i_z_re,
    input  wire logic signed [ftdp_pkg::SAMPLE_WIDTH-1:0] i_z_im,
    input  wire logic signed [ftdp_pkg::SAMPLE_WIDTH-1:0] i_p_re,
    input  wire logic signed [ftdp_pkg::SAMPLE_WIDTH-1:0] i_p_im,
    output logic signed [ftdp_pkg::SAMPLE_WIDTH-1:0]      o_re,
    output logic signed [ftdp_pkg::SAMPLE_WIDTH-1:0]      o_im
);

    localparam int SW = ftdp_pkg::SAMPLE_WIDTH;
    localparam int AW = SUM_WIDTH;
    localparam int PW = 2 * SW + 1;
    localparam int XW = ((PW > AW) ? PW : AW) + 1;
    localparam int QW = AW - SW + 1;

    localparam logic signed [AW-1:0] SMAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [XW-1:0] XMAX = {{(XW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [XW-1:0] XMIN = ~XMAX;
    localparam logic signed [XW-1:0] OMAX = {{(XW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [XW-1:0] OMIN = ~OMAX;
    localparam logic signed [AW-1:0] RND  = {{(AW-SW+1){1'b0}}, 1'b1, {(SW-2){1'b0}}};

    function automatic logic signed [AW-1:0] clamp_prod(input logic signed [PW-1:0] p);
        logic signed [XW-1:0] v;
        v = {{(XW-PW){p[PW-1]}}, p};
        if (v > XMAX) begin
            return SMAX;
        end else if (v < XMIN) begin
            return SMIN;
        end
        return v[AW-1:0];
    endfunction

    function automatic logic signed [AW-1:0] sat_add(
        input logic signed [AW-1:0] a,
        input logic signed [AW-1:0] b
    );
        logic signed [AW:0] s;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW] != s[AW-1]) begin
            return s[AW] ? SMIN : SMAX;
        end
        return s[AW-1:0];
    endfunction

    // add half an LSB, floor, then saturate to the sample range
    function automatic logic signed [SW-1:0] round_out(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r;
        logic signed [QW-1:0] q;
        logic signed [XW-1:0] e;
        r = sat_add(v, RND);
        q = r[AW-1:SW-1];
        e = {{(XW-QW){q[QW-1]}}, q};
        if (e > OMAX) begin
            return OMAX[SW-1:0];
        end else if (e < OMIN) begin
            return OMIN[SW-1:0];
        end
        return e[SW-1:0];
    endfunction

    logic signed [SW:0]   neg_ai;
    logic signed [SW:0]   pos_ai;
    logic signed [SW:0]   neg_bi;

    logic signed [PW-1:0] r_m_rr, r_m_ni, r_m_ri, r_m_pi;
    logic signed [PW-1:0] r_b_rr, r_b_ni, r_b_ri, r_b_pi;
    logic signed [AW-1:0] r_s_re, r_s_im, r_sb_re, r_sb_im;
    logic signed [AW-1:0] r_acc_re, r_acc_im, n_acc_re, n_acc_im;
    logic signed [AW-1:0] r_snap_re, r_snap_im, r_b4_re, r_b4_im;
    logic signed [AW-1:0] r_t_re, r_t_im;
    logic signed [SW-1:0] r_out_re, r_out_im;

    always_comb begin
        pos_ai = i_conj ? -{i_a_im[SW-1], i_a_im} : {i_a_im[SW-1], i_a_im};
        neg_ai = i_conj ? {i_a_im[SW-1], i_a_im} : -{i_a_im[SW-1], i_a_im};
        neg_bi = -{i_beta_im[SW-1], i_beta_im};
        n_acc_re = sat_add(r_acc_re, r_s_re);
        n_acc_im = sat_add(r_acc_im, r_s_im);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_m_rr <= PW'(i_a_re) * PW'(i_z_re);
            r_m_ni <= PW'(neg_ai) * PW'(i_z_im);
            r_m_ri <= PW'(i_a_re) * PW'(i_z_im);
            r_m_pi <= PW'(pos_ai) * PW'(i_z_re);
            r_b_rr <= PW'(i_beta_re) * PW'(i_p_re);
            r_b_ni <= PW'(neg_bi) * PW'(i_p_im);
            r_b_ri <= PW'(i_beta_re) * PW'(i_p_im);
            r_b_pi <= PW'(i_beta_im) * PW'(i_p_re);
        end
        if (i_ctl.ld3) begin
            r_s_re  <= sat_add(clamp_prod(r_m_rr), clamp_prod(r_m_ni));
            r_s_im  <= sat_add(clamp_prod(r_m_ri), clamp_prod(r_m_pi));
            r_sb_re <= sat_add(clamp_prod(r_b_rr), clamp_prod(r_b_ni));
            r_sb_im <= sat_add(clamp_prod(r_b_ri), clamp_prod(r_b_pi));
        end
        if (i_ctl.ld4) begin
            r_snap_re <= n_acc_re;
            r_snap_im <= n_acc_im;
            r_b4_re   <= r_sb_re;
            r_b4_im   <= r_sb_im;
        end
        if (i_ctl.ld5) begin
            r_t_re <= sat_add(r_b4_re, r_snap_re);
            r_t_im <= sat_add(r_b4_im, r_snap_im);
        end
        if (i_ctl.ld_out) begin
            r_out_re <= round_out(r_t_re);
            r_out_im <= round_out(r_t_im);
        end
    end

    // accumulator: clear once the last element's sum has been captured
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc_re <= i_ctl.acc_clr ? '0 : n_acc_re;
            r_acc_im <= i_ctl.acc_clr ? '0 : n_acc_im;
        end
    end

    assign o_re = r_out_re;
    assign o_im = r_out_im;

endmodule

`default_nettype wire

// ===== design/ftdp_checker.sv =====
// ----------------------------------------------------------------------------
// ftdp_checker
// Port-level checks for the fused triple dot product, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ftdp_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire ftdp_pkg::t_out_item o_out_item
);

    // input backs up only behind a full, stalled output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result dropped or changed");

    a_reset_idle: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (!o_out_valid && !o_in_stall))
        else $error("not idle after reset");

endmodule

bind fused_triple_dot_product ftdp_checker u_ftdp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fused_triple_dot_product. A bit-accurate predictor
// follows every accepted item and queues the expected triple of dot products;
// a checker compares each result field by field. Directed cases, long vectors
// of extreme samples, a sweep over register settings with random vectors and
// a backpressure phase run in turn, with random idling on both channels in most phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     QUIET_LIMIT   = 2000;
    localparam int     SETTLE_CYCLES = 12;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     LONG_RUN      = 120;
    localparam int     SWEEP_ITEMS   = 225;
    localparam longint ACC_HI        = (64'sd1 <<< (ftdp_pkg::SUM_WIDTH - 1)) - 1;
    localparam longint ACC_LO        = -ACC_HI - 1;
    localparam logic signed [15:0] S_MAX = 16'sh7fff;
    localparam logic signed [15:0] S_MIN = 16'sh8000;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    ftdp_pkg::t_cfg_idx   cfg_idx  = ftdp_pkg::CFG_CONJUGATE;
    logic [15:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    ftdp_pkg::t_in_item   in_item  = '0;
    logic                 out_stall = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    ftdp_pkg::t_out_item  out_item;

    fused_triple_dot_product u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // predictor state
    logic              conj_mode = 1'b0;
    logic signed [15:0] beta_r   = '0;
    logic signed [15:0] beta_i   = '0;
    longint            dot_acc [6];
    logic signed [15:0] prior_vals [6];
    ftdp_pkg::t_out_item pending_dots [$];

    int  errors       = 0;
    int  items_sent   = 0;
    int  loads_sent   = 0;
    int  results_seen = 0;
    int  reg_writes   = 0;
    int  src_idle_pct = 29;
    int  sink_idle_pct = 29;
    logic holdoff_req = 1'b0;
    int  hold_left    = 0;
    int  quiet_cycles = 0;
    string field_names [6] = '{"xz_re", "xz_im", "yz_re", "yz_im", "wz_re", "wz_im"};

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint clip_acc(input longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    // both operands lie within the accumulator range, so the 64-bit sum is exact
    function automatic longint add_clip(input longint a, input longint b);
        return clip_acc(a + b);
    endfunction

    function automatic longint cross_mac(input longint a, input longint b,
                                         input longint c, input longint d);
        return add_clip(clip_acc(a * b), clip_acc(c * d));
    endfunction

    // round half toward plus infinity, then clamp to Q1.15
    function automatic logic signed [15:0] round_q15(input longint v);
        longint q;
        q = add_clip(v, 64'sd1 <<< 14) >>> 15;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    task automatic advance_dot_model(input ftdp_pkg::t_in_item it);
        logic signed [15:0] lane_in [6];
        logic signed [15:0] lane_out [6];
        longint zr, zi, ar, ai, pr, pi, br, bi, re, im;
        ftdp_pkg::t_out_item res;
        lane_in = '{it.x_re, it.x_im, it.y_re, it.y_im, it.w_re, it.w_im};
        if (it.op == ftdp_pkg::OP_LOAD) begin
            for (int k = 0; k < 6; k++) prior_vals[k] = lane_in[k];
            loads_sent++;
            return;
        end
        zr = longint'(it.z_re);
        zi = longint'(it.z_im);
        for (int k = 0; k < 3; k++) begin
            ar = longint'(lane_in[2*k]);
            ai = longint'(lane_in[2*k+1]);
            if (conj_mode) ai = -ai;
            re = cross_mac(ar, zr, -ai, zi);
            im = cross_mac(ar, zi, ai, zr);
            dot_acc[2*k]   = add_clip(dot_acc[2*k], re);
            dot_acc[2*k+1] = add_clip(dot_acc[2*k+1], im);
        end
        if (!it.last) return;
        br = longint'(beta_r);
        bi = longint'(beta_i);
        for (int k = 0; k < 3; k++) begin
            pr = longint'(prior_vals[2*k]);
            pi = longint'(prior_vals[2*k+1]);
            lane_out[2*k]   = round_q15(add_clip(cross_mac(br, pr, -bi, pi), dot_acc[2*k]));
            lane_out[2*k+1] = round_q15(add_clip(cross_mac(br, pi, bi, pr), dot_acc[2*k+1]));
            dot_acc[2*k]   = 0;
            dot_acc[2*k+1] = 0;
        end
        res.xz_re = lane_out[0];
        res.xz_im = lane_out[1];
        res.yz_re = lane_out[2];
        res.yz_im = lane_out[3];
        res.wz_re = lane_out[4];
        res.wz_im = lane_out[5];
        pending_dots.push_back(res);
    endtask

    // result checker and watchdog
    always @(posedge clk) begin : result_check
        ftdp_pkg::t_out_item want;
        logic signed [15:0] gv [6];
        logic signed [15:0] wv [6];
        logic in_acc, out_acc;
        in_acc  = in_valid && (in_stall === 1'b0);
        out_acc = rst_n && (out_valid === 1'b1) && !out_stall;
        if (out_acc) begin
            results_seen++;
            if (pending_dots.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none pending",
                                          results_seen));
            end else begin
                want = pending_dots.pop_front();
                gv = '{out_item.xz_re, out_item.xz_im, out_item.yz_re,
                       out_item.yz_im, out_item.wz_re, out_item.wz_im};
                wv = '{want.xz_re, want.xz_im, want.yz_re,
                       want.yz_im, want.wz_re, want.wz_im};
                for (int k = 0; k < 6; k++) begin
                    if (gv[k] !== wv[k])
                        report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                                  results_seen, field_names[k],
                                                  gv[k], wv[k]));
                end
            end
        end
        if (in_acc || out_acc || cfg_we) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without progress, %0d results pending",
                     quiet_cycles, pending_dots.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // receiver stall for the next cycle: a requested hold-off wins over random stalls
    always @(posedge clk) begin : sink_stall
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holdoff_req) begin
            out_stall   <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            holdoff_req <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
        end
    end

    task automatic send_item(input ftdp_pkg::t_in_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        items_sent++;
        advance_dot_model(it);
    endtask

    // drop valid, wait for every pending result, then let the pipeline settle
    task automatic wait_dots_done();
        in_valid <= 1'b0;
        while (pending_dots.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ftdp_pkg::t_cfg_idx idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ftdp_pkg::CFG_CONJUGATE: conj_mode = val[0];
            ftdp_pkg::CFG_BETA_RE:   beta_r    = val;
            ftdp_pkg::CFG_BETA_IM:   beta_i    = val;
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_config(input logic conj, input logic [15:0] br,
                              input logic [15:0] bi);
        wait_dots_done();
        write_reg(ftdp_pkg::CFG_CONJUGATE, {15'd0, conj});
        write_reg(ftdp_pkg::CFG_BETA_RE, br);
        write_reg(ftdp_pkg::CFG_BETA_IM, bi);
    endtask

    // extremes and small values near zero show up often; the rest is uniform
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return 16'($signed($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic ftdp_pkg::t_in_item data_item(input logic is_last);
        ftdp_pkg::t_in_item it;
        it.op   = ftdp_pkg::OP_DATA;
        it.x_re = pick_sample();
        it.x_im = pick_sample();
        it.y_re = pick_sample();
        it.y_im = pick_sample();
        it.w_re = pick_sample();
        it.w_im = pick_sample();
        it.z_re = pick_sample();
        it.z_im = pick_sample();
        it.last = is_last;
        return it;
    endfunction

    function automatic ftdp_pkg::t_in_item load_item();
        ftdp_pkg::t_in_item it;
        it      = data_item(1'($urandom));
        it.op   = ftdp_pkg::OP_LOAD;
        return it;
    endfunction

    function automatic ftdp_pkg::t_in_item make_item(input ftdp_pkg::t_op op,
            input logic signed [15:0] xr, input logic signed [15:0] xi,
            input logic signed [15:0] yr, input logic signed [15:0] yi,
            input logic signed [15:0] wr, input logic signed [15:0] wi,
            input logic signed [15:0] zr, input logic signed [15:0] zi,
            input logic is_last);
        ftdp_pkg::t_in_item it;
        it.op = op;
        it.x_re = xr; it.x_im = xi;
        it.y_re = yr; it.y_im = yi;
        it.w_re = wr; it.w_im = wi;
        it.z_re = zr; it.z_im = zi;
        it.last = is_last;
        return it;
    endfunction

    // random vectors, mostly short, with prior loads sprinkled in
    task automatic send_vectors(input int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 16);
            if ($urandom_range(0, 99) < 15) begin
                send_item(load_item());
                sent++;
            end
            for (int j = 0; j < len; j++) begin
                // a load in the middle of a vector must keep the running sums
                if ($urandom_range(0, 99) < 5) begin
                    send_item(load_item());
                    sent++;
                end
                send_item(data_item(j == len - 1));
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        set_config(1'b0, 16'h0000, 16'h0000);
        send_item(make_item(ftdp_pkg::OP_DATA, S_MAX, S_MAX, S_MIN, S_MIN, 0, S_MAX,
                            S_MAX, S_MIN, 1'b1));
        send_item(make_item(ftdp_pkg::OP_DATA, S_MIN, 0, S_MIN, S_MIN, S_MAX, S_MIN,
                            S_MIN, 0, 1'b1));
        // exact halves: +0.5 LSB rounds up, -0.5 LSB rounds to zero
        send_item(make_item(ftdp_pkg::OP_DATA, 128, 0, -128, 0, 128, 128, 128, 0, 1'b1));
        send_item(make_item(ftdp_pkg::OP_LOAD, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX,
                            S_MIN, S_MAX, 1'b1));
        set_config(1'b0, S_MAX, S_MIN);
        send_item(make_item(ftdp_pkg::OP_DATA, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_item(make_item(ftdp_pkg::OP_DATA, 1000, -2000, 300, 4, -5, 6, 7000, -8000,
                            1'b0));
        send_item(make_item(ftdp_pkg::OP_LOAD, -1, 1, 16'sh4000, 16'shc000, 0, S_MIN,
                            S_MAX, S_MAX, 1'b1));
        send_item(make_item(ftdp_pkg::OP_DATA, 12, 34, -56, 78, 90, -12, 345, 678, 1'b1));
        // prior stays in place for the next vector
        send_item(make_item(ftdp_pkg::OP_DATA, S_MAX, 0, 0, S_MAX, S_MIN, S_MIN,
                            16'sh2000, 16'sh2000, 1'b1));
        set_config(1'b1, S_MIN, S_MIN);
        send_item(make_item(ftdp_pkg::OP_DATA, S_MIN, S_MIN, 0, S_MIN, S_MAX, S_MIN,
                            S_MIN, S_MIN, 1'b0));
        send_item(make_item(ftdp_pkg::OP_DATA, 5, S_MIN, S_MIN, S_MAX, 1, -1,
                            S_MAX, S_MIN, 1'b1));
        set_config(1'b1, S_MAX, S_MAX);
        send_item(make_item(ftdp_pkg::OP_DATA, S_MIN, S_MAX, S_MAX, S_MIN, 0, 0,
                            S_MIN, S_MAX, 1'b1));
    endtask

    // drive every real-part accumulator far out in both directions with long extreme vectors
    task automatic test_long_vectors();
        set_config(1'b0, 16'h0000, 16'h0000);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int n = 0; n < LONG_RUN; n++)
            send_item(make_item(ftdp_pkg::OP_DATA, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                                S_MIN, S_MIN, S_MAX, 1'b0));
        for (int n = 0; n < 4; n++)
            send_item(make_item(ftdp_pkg::OP_DATA, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                                S_MAX, S_MIN, S_MAX, n == 3));
        for (int n = 0; n < LONG_RUN; n++)
            send_item(make_item(ftdp_pkg::OP_DATA, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                                S_MAX, S_MIN, S_MAX, 1'b0));
        send_item(make_item(ftdp_pkg::OP_DATA, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        wait_dots_done();
        src_idle_pct  = 29;
        sink_idle_pct = 29;
    endtask

    task automatic test_config_sweep();
        set_config(1'b0, 16'h0000, 16'h0000);
        send_vectors(SWEEP_ITEMS);
        set_config(1'b1, S_MAX, S_MAX);
        // a stretch with no idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_vectors(SWEEP_ITEMS);
        src_idle_pct  = 29;
        sink_idle_pct = 29;
        set_config(1'b0, S_MIN, S_MIN);
        send_vectors(SWEEP_ITEMS);
        set_config(1'b1, S_MIN, S_MAX);
        send_vectors(SWEEP_ITEMS);
        for (int p = 0; p < 2; p++) begin
            set_config(1'($urandom), 16'($urandom), 16'($urandom));
            send_vectors(SWEEP_ITEMS);
        end
    endtask

    task automatic test_backpressure();
        wait_dots_done();
        src_idle_pct = 0;
        holdoff_req  = 1'b1;
        for (int n = 0; n < 60; n++)
            send_item(data_item(1'b1));
        // pause the sender until every result is out
        wait_dots_done();
        src_idle_pct = 29;
        send_vectors(60);
        wait_dots_done();
    endtask

    initial begin
        for (int k = 0; k < 6; k++) begin
            dot_acc[k]    = 0;
            prior_vals[k] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_vectors();
        test_config_sweep();
        test_backpressure();
        wait_dots_done();
        if (pending_dots.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_dots.size()));
        $display("covered %0d items (%0d prior loads), %0d results, %0d register writes",
                 items_sent, loads_sent, results_seen, reg_writes);
        $display("including long extreme-valued vectors and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
